>>> design/rbst_pkg.sv
// ----------------------------------------------------------------------------
// Ray box slab test package
// Shared widths, infinity codes, register indexes and types of the slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   // Dividend magnitude: |bound - origin| fits 32 unsigned bits, then scaled.
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   // Distances carry two extra bits so that the infinity codes stay apart.
   localparam int TW        = NUM_W + 2;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_AXES  = 3;

   localparam logic signed [TW-1:0] NEG_INF = {1'b1, {(TW-1){1'b0}}};
   localparam logic signed [TW-1:0] POS_INF = {1'b0, {(TW-1){1'b1}}};
   localparam logic signed [TW-1:0] SAT_MAX = {{(TW-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [TW-1:0] SAT_MIN = {{(TW-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_Z = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

   // Per-axis data that rides alongside the dividers.
   typedef struct packed {
      logic signed [DATA_W-1:0] orig;
      logic signed [DATA_W-1:0] dir;
      logic                     zero;
      logic                     in_slab;
   } side_type;

   // Ordered slab bounds of one axis.
   typedef struct packed {
      logic signed [TW-1:0] t_lo;
      logic signed [TW-1:0] t_hi;
      logic                 ok;
   } slab_type;

endpackage

>>> design/rbst_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; takes a new division every cycle and
// returns the signed, truncated quotient from an output register after the last stage.
// ----------------------------------------------------------------------------
module rbst_div
   import rbst_pkg::*;
(
   input  logic                 clock,
   input  logic [NUM_W-1:0]     in_num,
   input  logic [DATA_W-1:0]    in_den,
   input  logic                 in_neg,
   output logic signed [TW-1:0] out_quot
);

   logic [DATA_W-1:0] rem_ff [NUM_W];
   logic [DATA_W-1:0] rem_in [NUM_W];
   logic [NUM_W-1:0]  nq_ff  [NUM_W];
   logic [NUM_W-1:0]  nq_in  [NUM_W];
   logic [DATA_W-1:0] den_ff [NUM_W];
   logic [DATA_W-1:0] den_in [NUM_W];
   logic              neg_ff [NUM_W];
   logic              neg_in [NUM_W];
   logic signed [TW-1:0] quot_ff;
   logic signed [TW-1:0] quot_in;

   // Each stage brings down one dividend bit and shifts in one quotient bit.
   always_comb begin
      logic [DATA_W-1:0] rem_prev;
      logic [NUM_W-1:0]  nq_prev;
      logic [DATA_W:0]   shifted;
      logic              ge;
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            rem_prev  = '0;
            nq_prev   = in_num;
            den_in[k] = in_den;
            neg_in[k] = in_neg;
         end else begin
            rem_prev  = rem_ff[k-1];
            nq_prev   = nq_ff[k-1];
            den_in[k] = den_ff[k-1];
            neg_in[k] = neg_ff[k-1];
         end
         shifted   = {rem_prev, nq_prev[NUM_W-1]};
         ge        = (shifted >= {1'b0, den_in[k]});
         rem_in[k] = ge ? DATA_W'(shifted - {1'b0, den_in[k]}) : shifted[DATA_W-1:0];
         nq_in[k]  = {nq_prev[NUM_W-2:0], ge};
      end
   end

   assign quot_in = neg_ff[NUM_W-1] ? -$signed({2'b00, nq_ff[NUM_W-1]})
                                    :  $signed({2'b00, nq_ff[NUM_W-1]});

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_W; k++) begin
         rem_ff[k] <= rem_in[k];
         nq_ff[k]  <= nq_in[k];
         den_ff[k] <= den_in[k];
         neg_ff[k] <= neg_in[k];
      end
      quot_ff <= quot_in;
   end

   assign out_quot = quot_ff;

endmodule

>>> design/rbst_point.sv
// ----------------------------------------------------------------------------
// Entry point of one axis
// Two stages: the product t * dir, then origin plus the floored, scaled
// product, saturated to 32 bits and cleared on a miss.
// ----------------------------------------------------------------------------
module rbst_point
   import rbst_pkg::*;
(
   input  logic                     clock,
   input  logic                     in_hit,
   input  logic signed [DATA_W-1:0] in_t,
   input  logic signed [DATA_W-1:0] in_orig,
   input  logic signed [DATA_W-1:0] in_dir,
   output logic signed [DATA_W-1:0] out_p
);

   localparam int PW = 2 * DATA_W;
   localparam int SW = PW - FRAC_BITS + 1;

   logic signed [PW-1:0]     prod_ff;
   logic signed [DATA_W-1:0] orig_ff;
   logic                     hit_ff;
   logic signed [SW-1:0]     sum;
   logic signed [DATA_W-1:0] sat;
   logic signed [DATA_W-1:0] p_ff;
   logic signed [DATA_W-1:0] p_in;

   always_ff @(posedge clock) begin
      prod_ff <= PW'(in_t) * PW'(in_dir);
      orig_ff <= in_orig;
      hit_ff  <= in_hit;
   end

   // An arithmetic shift of the product is a floor division by the scale.
   assign sum = SW'(orig_ff) + SW'($signed(prod_ff[PW-1:FRAC_BITS]));

   always_comb begin
      if (sum > SW'(SAT_MAX)) begin
         sat = SAT_MAX[DATA_W-1:0];
      end else if (sum < SW'(SAT_MIN)) begin
         sat = SAT_MIN[DATA_W-1:0];
      end else begin
         sat = sum[DATA_W-1:0];
      end
   end

   assign p_in = hit_ff ? sat : '0;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign out_p = p_ff;

endmodule

>>> design/ray_box_slab_test_top.sv
// ----------------------------------------------------------------------------
// Ray box slab test
// Fixed-point slab intersection of a ray with an axis-aligned box.
// ----------------------------------------------------------------------------
// Results pass through stage 1, the 48-stage bit-per-stage dividers and stages A to D.
// Throughput: one ray per cycle; busy never rises and results cannot be held.
// Reset (synchronous, active high) clears the valid pipeline and the six box
// registers to zero; beats in flight at reset are dropped.
module ray_box_slab_test_top
   import rbst_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // Ray input channel.
   input  logic                        start,
   output logic                        busy,
   input  logic signed [DATA_W-1:0]    req_orig_x,
   input  logic signed [DATA_W-1:0]    req_orig_y,
   input  logic signed [DATA_W-1:0]    req_orig_z,
   input  logic signed [DATA_W-1:0]    req_dir_x,
   input  logic signed [DATA_W-1:0]    req_dir_y,
   input  logic signed [DATA_W-1:0]    req_dir_z,
   // Result channel.
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic signed [DATA_W-1:0]    rsp_t_entry,
   output logic signed [DATA_W-1:0]    rsp_hit_px,
   output logic signed [DATA_W-1:0]    rsp_hit_py,
   output logic signed [DATA_W-1:0]    rsp_hit_pz,
   // Box register write channel.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

   localparam int LAT = NUM_W + 6;

   // The pipeline never stalls, so both channels are always open.
   logic accept;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // ---------------------------------------------------------------------
   // Box registers. The user must write them only while no ray is in flight;
   // the block itself does not enforce this.
   logic signed [DATA_W-1:0] box_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            box_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BOX_MIN_X: box_ff[0] <= csr_wdata;
            REG_BOX_MAX_X: box_ff[1] <= csr_wdata;
            REG_BOX_MIN_Y: box_ff[2] <= csr_wdata;
            REG_BOX_MAX_Y: box_ff[3] <= csr_wdata;
            REG_BOX_MIN_Z: box_ff[4] <= csr_wdata;
            REG_BOX_MAX_Z: box_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Valid pipeline. One bit per register stage of the datapath.
   // ---------------------------------------------------------------------
   logic v_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[0] <= accept;
         for (int i = 1; i < LAT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: per axis, the differences bound - origin become unsigned
   // scaled dividends with a quotient sign, and the zero-direction case is
   // resolved against the box now, while the registers are steady.
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] orig [NUM_AXES];
   logic signed [DATA_W-1:0] dir  [NUM_AXES];

   assign orig[0] = req_orig_x;
   assign orig[1] = req_orig_y;
   assign orig[2] = req_orig_z;
   assign dir[0]  = req_dir_x;
   assign dir[1]  = req_dir_y;
   assign dir[2]  = req_dir_z;

   logic [NUM_W-1:0]  num_lo_ff [NUM_AXES];
   logic [NUM_W-1:0]  num_lo_in [NUM_AXES];
   logic [NUM_W-1:0]  num_hi_ff [NUM_AXES];
   logic [NUM_W-1:0]  num_hi_in [NUM_AXES];
   logic              neg_lo_ff [NUM_AXES];
   logic              neg_lo_in [NUM_AXES];
   logic              neg_hi_ff [NUM_AXES];
   logic              neg_hi_in [NUM_AXES];
   logic [DATA_W-1:0] den_ff    [NUM_AXES];
   logic [DATA_W-1:0] den_in    [NUM_AXES];
   side_type          s1_ff     [NUM_AXES];
   side_type          s1_in     [NUM_AXES];

   always_comb begin
      logic signed [DATA_W:0] diff_lo;
      logic signed [DATA_W:0] diff_hi;
      logic [DATA_W:0]        mag_lo;
      logic [DATA_W:0]        mag_hi;
      for (int a = 0; a < NUM_AXES; a++) begin
         diff_lo = (DATA_W+1)'(box_ff[2*a]) - (DATA_W+1)'(orig[a]);
         diff_hi = (DATA_W+1)'(box_ff[2*a+1]) - (DATA_W+1)'(orig[a]);
         mag_lo  = diff_lo[DATA_W] ? (DATA_W+1)'(-diff_lo) : diff_lo;
         mag_hi  = diff_hi[DATA_W] ? (DATA_W+1)'(-diff_hi) : diff_hi;
         num_lo_in[a] = {mag_lo[DATA_W-1:0], {FRAC_BITS{1'b0}}};
         num_hi_in[a] = {mag_hi[DATA_W-1:0], {FRAC_BITS{1'b0}}};
         neg_lo_in[a] = diff_lo[DATA_W] ^ dir[a][DATA_W-1];
         neg_hi_in[a] = diff_hi[DATA_W] ^ dir[a][DATA_W-1];
         den_in[a]    = dir[a][DATA_W-1] ? DATA_W'(-dir[a]) : dir[a];
         s1_in[a].orig    = orig[a];
         s1_in[a].dir     = dir[a];
         s1_in[a].zero    = (dir[a] == '0);
         s1_in[a].in_slab = (orig[a] >= box_ff[2*a]) && (orig[a] <= box_ff[2*a+1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         num_lo_ff[a] <= num_lo_in[a];
         num_hi_ff[a] <= num_hi_in[a];
         neg_lo_ff[a] <= neg_lo_in[a];
         neg_hi_ff[a] <= neg_hi_in[a];
         den_ff[a]    <= den_in[a];
         s1_ff[a]     <= s1_in[a];
      end
   end

   // ---------------------------------------------------------------------
   // Dividers: two per axis. The side data is delayed by a matching line
   // so that it meets the quotients at the divider outputs.
   // ---------------------------------------------------------------------
   logic signed [TW-1:0] q_lo [NUM_AXES];
   logic signed [TW-1:0] q_hi [NUM_AXES];

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis_div
      rbst_div u_div_lo (
         .clock    (clock),
         .in_num   (num_lo_ff[a]),
         .in_den   (den_ff[a]),
         .in_neg   (neg_lo_ff[a]),
         .out_quot (q_lo[a])
      );
      rbst_div u_div_hi (
         .clock    (clock),
         .in_num   (num_hi_ff[a]),
         .in_den   (den_ff[a]),
         .in_neg   (neg_hi_ff[a]),
         .out_quot (q_hi[a])
      );
   end

   side_type side_ff [NUM_W+1][NUM_AXES];

   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         side_ff[0][a] <= s1_ff[a];
         for (int i = 1; i <= NUM_W; i++) begin
            side_ff[i][a] <= side_ff[i-1][a];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: put each axis's distances in order. A zero direction with
   // the origin inside the slab bounds nothing; outside it is a miss.
   // ---------------------------------------------------------------------
   slab_type slab_ff [NUM_AXES];
   slab_type slab_in [NUM_AXES];
   side_type sa_ff   [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (side_ff[NUM_W][a].zero) begin
            slab_in[a].t_lo = NEG_INF;
            slab_in[a].t_hi = POS_INF;
            slab_in[a].ok   = side_ff[NUM_W][a].in_slab;
         end else if (q_lo[a] > q_hi[a]) begin
            slab_in[a].t_lo = q_hi[a];
            slab_in[a].t_hi = q_lo[a];
            slab_in[a].ok   = 1'b1;
         end else begin
            slab_in[a].t_lo = q_lo[a];
            slab_in[a].t_hi = q_hi[a];
            slab_in[a].ok   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         slab_ff[a] <= slab_in[a];
         sa_ff[a]   <= side_ff[NUM_W][a];
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: combined entry is the largest entry, combined exit the
   // smallest exit. The entry distance is saturated to 32 bits and is
   // forced to zero on a miss.
   // ---------------------------------------------------------------------
   logic signed [TW-1:0]     enter;
   logic signed [TW-1:0]     leave;
   logic                     hit_in;
   logic signed [DATA_W-1:0] t_in;
   logic                     hit_ff;
   logic signed [DATA_W-1:0] t_ff;
   side_type                 sb_ff [NUM_AXES];

   always_comb begin
      enter = slab_ff[0].t_lo;
      leave = slab_ff[0].t_hi;
      for (int a = 1; a < NUM_AXES; a++) begin
         if (slab_ff[a].t_lo > enter) begin
            enter = slab_ff[a].t_lo;
         end
         if (slab_ff[a].t_hi < leave) begin
            leave = slab_ff[a].t_hi;
         end
      end
      hit_in = slab_ff[0].ok && slab_ff[1].ok && slab_ff[2].ok && (enter <= leave);
      if (!hit_in) begin
         t_in = '0;
      end else if (enter > SAT_MAX) begin
         t_in = SAT_MAX[DATA_W-1:0];
      end else if (enter < SAT_MIN) begin
         t_in = SAT_MIN[DATA_W-1:0];
      end else begin
         t_in = enter[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      t_ff   <= t_in;
      for (int a = 0; a < NUM_AXES; a++) begin
         sb_ff[a] <= sa_ff[a];
      end
   end

   // ---------------------------------------------------------------------
   // Stages C and D: the entry point on each axis. The hit flag and the
   // entry distance travel alongside through two matching registers.
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] pnt [NUM_AXES];

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis_pnt
      rbst_point u_point (
         .clock   (clock),
         .in_hit  (hit_ff),
         .in_t    (t_ff),
         .in_orig (sb_ff[a].orig),
         .in_dir  (sb_ff[a].dir),
         .out_p   (pnt[a])
      );
   end

   logic                     hit_c_ff;
   logic signed [DATA_W-1:0] t_c_ff;
   logic                     hit_d_ff;
   logic signed [DATA_W-1:0] t_d_ff;

   always_ff @(posedge clock) begin
      hit_c_ff <= hit_ff;
      t_c_ff   <= t_ff;
      hit_d_ff <= hit_c_ff;
      t_d_ff   <= t_c_ff;
   end

   assign rsp_valid   = v_ff[LAT-1];
   assign rsp_hit     = hit_d_ff;
   assign rsp_t_entry = t_d_ff;
   assign rsp_hit_px  = pnt[0];
   assign rsp_hit_py  = pnt[1];
   assign rsp_hit_pz  = pnt[2];

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted ray gave no result beat at the fixed latency");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_t_entry == '0 && rsp_hit_px == '0 &&
                                   rsp_hit_py == '0 && rsp_hit_pz == '0))
      else $error("miss beat carries nonzero distance or point");

   a_reset_flush : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

>>> sim/ray_box_slab_test_top_tb.sv
// ----------------------------------------------------------------------------
// Ray box slab test bench
// Drives rays through the slab intersection block under several box settings,
// predicts every result in 64-bit integer arithmetic and compares each result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ray_box_slab_test_top_tb;
   import rbst_pkg::*;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct {
      word_type orig [NUM_AXES];
      word_type dir  [NUM_AXES];
   } ray_type;

   typedef struct {
      logic     hit;
      word_type t_entry;
      word_type pnt [NUM_AXES];
   } slab_result_type;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = NUM_W + 20;
   localparam int RANDOM_PER_BOX = 175;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   word_type req_orig_x, req_orig_y, req_orig_z;
   word_type req_dir_x, req_dir_y, req_dir_z;
   logic rsp_valid;
   logic rsp_hit;
   word_type rsp_t_entry, rsp_hit_px, rsp_hit_py, rsp_hit_pz;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_wdata;

   ray_box_slab_test_top dut (.*);

   // Our own copy of the six box registers, index order lo/hi per axis.
   word_type box_lo [NUM_AXES];
   word_type box_hi [NUM_AXES];

   ray_type         rays_to_send [$];
   slab_result_type hits_awaited [$];
   ray_type         ray_on_bus;
   int              gap_left;
   bit              no_idle;
   int              errors;
   int              quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Slab intersection worked out exactly in 64 bits. Distances stay unsaturated
   // for the comparisons; only the reported entry distance and points are clamped.
   function automatic slab_result_type predict_slab(ray_type r);
      slab_result_type res;
      longint o, d, a, b, swap, enter, leave, t, p;
      bit ok;
      ok = 1'b1;
      enter = 64'sh8000_0000_0000_0000;
      leave = 64'sh7fff_ffff_ffff_ffff;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         o = r.orig[ax];
         d = r.dir[ax];
         if (d == 0) begin
            // A flat component bounds nothing when the origin is in the slab.
            if (!(o >= longint'(box_lo[ax]) && o <= longint'(box_hi[ax])))
               ok = 1'b0;
         end else begin
            a = ((longint'(box_lo[ax]) - o) * (64'sd1 << FRAC_BITS)) / d;
            b = ((longint'(box_hi[ax]) - o) * (64'sd1 << FRAC_BITS)) / d;
            if (a > b) begin
               swap = a; a = b; b = swap;
            end
            if (a > enter) enter = a;
            if (b < leave) leave = b;
         end
      end
      res.hit = 1'b0;
      res.t_entry = '0;
      for (int ax = 0; ax < NUM_AXES; ax++) res.pnt[ax] = '0;
      if (ok && enter <= leave) begin
         t = sat_word(enter);
         res.hit = 1'b1;
         res.t_entry = word_type'(t);
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            // Arithmetic shift of a signed value rounds toward minus infinity.
            p = longint'(r.orig[ax]) + ((t * longint'(r.dir[ax])) >>> FRAC_BITS);
            res.pnt[ax] = word_type'(sat_word(p));
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
      errors++;
   endtask

   // Ray driver. It only ever assigns start once per edge, so a ray that
   // follows straight after an accepted beat keeps start high.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
         no_idle <= 1'b0;
      end else begin
         if (start && !busy)
            hits_awaited.push_back(predict_slab(ray_on_bus));
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (rays_to_send.size() > 0) begin
               ray_on_bus <= rays_to_send[0];
               req_orig_x <= rays_to_send[0].orig[0];
               req_orig_y <= rays_to_send[0].orig[1];
               req_orig_z <= rays_to_send[0].orig[2];
               req_dir_x <= rays_to_send[0].dir[0];
               req_dir_y <= rays_to_send[0].dir[1];
               req_dir_z <= rays_to_send[0].dir[2];
               void'(rays_to_send.pop_front());
               start <= 1'b1;
               // Now and then switch between gappy traffic and back-to-back bursts.
               if ($urandom_range(0, 31) == 0) no_idle <= ~no_idle;
               gap_left <= no_idle ? 0 : $urandom_range(0, 3);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor. A result beat lives for one cycle and is taken here.
   always @(posedge clock) begin
      slab_result_type want;
      if (!reset && rsp_valid) begin
         if (hits_awaited.size() == 0) begin
            $display("result beat with no ray outstanding at %0t", $time);
            errors++;
         end else begin
            want = hits_awaited.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", want.hit, rsp_hit);
            if (rsp_t_entry !== want.t_entry)
               report_mismatch("t_entry", want.t_entry, rsp_t_entry);
            if (rsp_hit_px !== want.pnt[0]) report_mismatch("hit_px", want.pnt[0], rsp_hit_px);
            if (rsp_hit_py !== want.pnt[1]) report_mismatch("hit_py", want.pnt[1], rsp_hit_py);
            if (rsp_hit_pz !== want.pnt[2]) report_mismatch("hit_pz", want.pnt[2], rsp_hit_pz);
         end
      end
   end

   // Watchdog: any accepted beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout with %0d results outstanding", hits_awaited.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_box_reg(logic [CSR_IDX_W-1:0] idx, word_type val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_BOX_MIN_X: box_lo[0] = val;
         REG_BOX_MAX_X: box_hi[0] = val;
         REG_BOX_MIN_Y: box_lo[1] = val;
         REG_BOX_MAX_Y: box_hi[1] = val;
         REG_BOX_MIN_Z: box_lo[2] = val;
         REG_BOX_MAX_Z: box_hi[2] = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic load_box(word_type lx, word_type hx, word_type ly, word_type hy,
                           word_type lz, word_type hz);
      write_box_reg(REG_BOX_MIN_X, lx);
      write_box_reg(REG_BOX_MAX_X, hx);
      write_box_reg(REG_BOX_MIN_Y, ly);
      write_box_reg(REG_BOX_MAX_Y, hy);
      write_box_reg(REG_BOX_MIN_Z, lz);
      write_box_reg(REG_BOX_MAX_Z, hz);
   endtask

   // Waits until every queued ray is out and every result has come back.
   task automatic drain_rays();
      do @(posedge clock);
      while (rays_to_send.size() != 0 || start || hits_awaited.size() != 0);
   endtask

   task automatic queue_ray(word_type ox, word_type oy, word_type oz,
                            word_type dx, word_type dy, word_type dz);
      ray_type r;
      r.orig[0] = ox; r.orig[1] = oy; r.orig[2] = oz;
      r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
      rays_to_send.push_back(r);
   endtask

   // Coordinates: mostly within ten units of zero, sometimes full range.
   function automatic word_type rand_coord();
      case ($urandom_range(0, 9))
         0: return word_type'($urandom);
         1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return word_type'($urandom_range(0, 32'h0014_0000)) - 32'sh000a_0000;
      endcase
   endfunction

   // Direction parts: mostly within one unit, with flat and wild components.
   function automatic word_type rand_dir();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return word_type'($urandom);
         2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return word_type'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      endcase
   endfunction

   // Mostly rays aimed toward the box center, which is where hits
   // and entry points get exercised; the rest is unconstrained noise.
   task automatic queue_random_rays(int count);
      word_type o [NUM_AXES];
      word_type d [NUM_AXES];
      longint mid;
      for (int n = 0; n < count; n++) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            o[ax] = rand_coord();
            d[ax] = rand_dir();
            if ($urandom_range(0, 3) != 0 && d[ax] != 0) begin
               mid = (longint'(box_lo[ax]) + longint'(box_hi[ax])) >>> 1;
               if ((mid > o[ax]) != (d[ax] > 0)) d[ax] = -d[ax];
            end
         end
         queue_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
      end
   endtask

   localparam word_type ONE = 32'sh0001_0000;
   localparam word_type MAXW = 32'sh7fff_ffff;
   localparam word_type MINW = 32'sh8000_0000;

   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      {req_orig_x, req_orig_y, req_orig_z} = '0;
      {req_dir_x, req_dir_y, req_dir_z} = '0;
      errors = 0;
      quiet_cycles = 0;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         box_lo[ax] = '0;
         box_hi[ax] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Degenerate box out of reset: a point at the origin.
      queue_ray('0, '0, '0, '0, '0, '0);
      queue_ray(ONE, '0, '0, '0, '0, '0);
      queue_ray(-ONE, '0, '0, ONE, '0, '0);
      queue_random_rays(40);
      drain_rays();

      // Unit box with directed cases.
      load_box(-ONE, ONE, -ONE, ONE, -ONE, ONE);
      queue_ray('0, '0, '0, '0, '0, '0);                 // inside, all flat
      queue_ray(2 * ONE, '0, '0, '0, '0, '0);            // outside, all flat
      queue_ray(-3 * ONE, '0, '0, ONE, '0, '0);          // straight hit
      queue_ray(3 * ONE, '0, '0, ONE, '0, '0);           // box behind origin
      queue_ray(-3 * ONE, 2 * ONE, '0, ONE, '0, '0);     // flat axis outside
      queue_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE);
      queue_ray(-3 * ONE, 3 * ONE, '0, ONE, -ONE, '0);
      queue_ray(-3 * ONE, '0, '0, 1, '0, '0);            // tiny direction
      queue_ray(-3 * ONE, '0, '0, MAXW, MINW, '0);
      queue_ray(MINW, MINW, MINW, MAXW, MAXW, MAXW);
      queue_ray(MAXW, MAXW, MAXW, MINW, MINW, MINW);
      queue_ray(MAXW, '0, '0, MINW, '0, '0);
      queue_ray('0, '0, '0, MINW, MAXW, 1);
      queue_ray(-3 * ONE, 5 * ONE, '0, ONE, '0, ONE);    // slabs do not overlap
      queue_ray(ONE, ONE, ONE, ONE, '0, '0);             // origin on a corner
      queue_ray(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
      queue_random_rays(RANDOM_PER_BOX);
      drain_rays();

      // Indexes past the last register must be ignored.
      write_box_reg(3'd6, 32'sh1234_5678);
      write_box_reg(3'd7, MINW);
      queue_random_rays(20);
      drain_rays();

      // Full-range box.
      load_box(MINW, MAXW, MINW, MAXW, MINW, MAXW);
      queue_ray(MINW, MAXW, '0, '0, '0, '0);
      queue_ray('0, '0, '0, 1, -32'sd1, 1);
      queue_random_rays(RANDOM_PER_BOX);
      drain_rays();

      // Inverted box: the flat-component case always misses here.
      load_box(ONE, -ONE, 2 * ONE, -2 * ONE, ONE, '0);
      queue_ray('0, '0, '0, '0, '0, '0);
      queue_ray(-3 * ONE, '0, '0, ONE, ONE, ONE);
      queue_random_rays(RANDOM_PER_BOX);
      drain_rays();

      // A long thin off-center box and then random boxes.
      load_box(5 * ONE, 40 * ONE, -32'sd3, 32'sd3, MINW, -7 * ONE);
      queue_random_rays(RANDOM_PER_BOX);
      drain_rays();
      for (int k = 0; k < 3; k++) begin
         load_box(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord());
         queue_random_rays(RANDOM_PER_BOX / 2);
         drain_rays();
      end

      // Let anything still in the pipeline surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && hits_awaited.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
